// ===== src/lps_pkg.sv =====
// lps_pkg: shared types and fixed widths of the longest palindromic subsequence block
// no dependencies; used by the channel interfaces, lps_fill and the top level
`default_nettype none

package lps_pkg;

	// fixed payload widths
	localparam int SYM_W = 8;
	localparam int LEN_W = 7;

	// load/score/deliver control of the top level
	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_FILL = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// table fill sequencer phases, also used to tag the s1 stage
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PRIME = 3'b010,
		PH_CELL  = 3'b100
	} phase_t;

	// status from the fill sequencer to the top level
	typedef struct packed {
		logic busy;
		logic done;
	} fill_status_t;

endpackage

`default_nettype wire

// ===== src/lps_if.sv =====
// lps_if: valid/ready channels for symbol beats in and result beats out
// depends on lps_pkg for payload widths
`default_nettype none

interface lps_in_if;
	logic                     valid;
	logic                     ready;
	logic [lps_pkg::SYM_W-1:0] symbol;
	logic                     last_symbol;

	modport source (output valid, output symbol, output last_symbol, input ready);
	modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

interface lps_out_if;
	logic                     valid;
	logic                     ready;
	logic [lps_pkg::LEN_W-1:0] lps_length;
	logic                     overflowed;

	modport source (output valid, output lps_length, output overflowed, input ready);
	modport sink (input valid, input lps_length, input overflowed, output ready);
endinterface

`default_nettype wire

// ===== src/lps_ram.sv =====
// lps_ram: synchronous memory, one write port and two registered read ports
// no dependencies; holds the symbol store and the interval table
`default_nettype none

module lps_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
	input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
	output logic [DW-1:0]            rd_a_data,
	output logic [DW-1:0]            rd_b_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rd_a_data <= mem[rd_a_addr];
		rd_b_data <= mem[rd_b_addr];
	end

endmodule

`default_nettype wire

// ===== src/lps_fill.sv =====
// lps_fill: diagonal-by-diagonal interval table fill, one cell per cycle apart from a prime slot between diagonals
// depends on lps_pkg; drives both read ports of both lps_ram instances and the write port of the table
`default_nettype none

module lps_fill #(
	parameter int MAX_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [$clog2(MAX_LEN)-1:0]    nm1,
	output logic [$clog2(MAX_LEN)-1:0]    sym_a_addr,
	output logic [$clog2(MAX_LEN)-1:0]    sym_b_addr,
	input  logic [lps_pkg::SYM_W-1:0]     sym_a_rd,
	input  logic [lps_pkg::SYM_W-1:0]     sym_b_rd,
	output logic [2*$clog2(MAX_LEN)-1:0]  tab_a_addr,
	output logic [2*$clog2(MAX_LEN)-1:0]  tab_b_addr,
	input  logic [$clog2(MAX_LEN+1)-1:0]  tab_a_rd,
	input  logic [$clog2(MAX_LEN+1)-1:0]  tab_b_rd,
	output logic                          tab_wr_en,
	output logic [2*$clog2(MAX_LEN)-1:0]  tab_wr_addr,
	output logic [$clog2(MAX_LEN+1)-1:0]  tab_wr_data,
	output lps_pkg::fill_status_t         status,
	output logic [$clog2(MAX_LEN+1)-1:0]  result
);

	import lps_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int VW = $clog2(MAX_LEN + 1);

	phase_t        phase_q;
	logic [AW-1:0] gap_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] nm1_q;

	logic [AW-1:0] j;
	logic [AW-1:0] i_p1;
	logic [AW-1:0] j_m1;
	logic [AW-1:0] gap_m1;
	logic          diag_end;
	logic          last_diag;

	phase_t        op_s1;
	logic [AW-1:0] i_s1;
	logic [AW-1:0] j_s1;
	logic          gap0_s1;
	logic          gap_ge2_s1;
	logic          final_s1;

	logic [VW-1:0] b_q;
	logic [VW-1:0] inner;
	logic [VW-1:0] best;
	logic [VW-1:0] cell_val;

	// cell coordinates of the current issue slot
	assign j         = i_q + gap_q;
	assign i_p1      = i_q + AW'(1);
	assign j_m1      = j - AW'(1);
	assign gap_m1    = gap_q - AW'(1);
	assign diag_end  = (j == nm1_q);
	assign last_diag = (gap_q == nm1_q);

	// read issue: symbols at both ends, table at the lower neighbour and the inner interval;
	// the prime slot fetches the left neighbour of the first cell of a diagonal
	assign sym_a_addr = i_q;
	assign sym_b_addr = j;
	assign tab_a_addr = (phase_q == PH_PRIME) ? {AW'(0), gap_m1} : {i_p1, j};
	assign tab_b_addr = {i_p1, j_m1};

	// sequencer: a prime slot between diagonals also keeps reads behind the last write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_CELL;
					end
				end
				PH_CELL: begin
					if (diag_end) begin
						phase_q <= last_diag ? PH_IDLE : PH_PRIME;
					end
				end
				PH_PRIME: begin
					phase_q <= PH_CELL;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// cell counters
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE) begin
			nm1_q <= nm1;
			gap_q <= '0;
			i_q   <= '0;
		end else if (phase_q == PH_CELL) begin
			if (diag_end) begin
				gap_q <= gap_q + AW'(1);
				i_q   <= '0;
			end else begin
				i_q <= i_p1;
			end
		end
	end

	// s1 tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= PH_IDLE;
		end else begin
			op_s1 <= phase_q;
		end
	end

	// s1 payload
	always_ff @(posedge clk) begin
		i_s1       <= i_q;
		j_s1       <= j;
		gap0_s1    <= (gap_q == '0);
		gap_ge2_s1 <= (gap_q > AW'(1));
		final_s1   <= diag_end && last_diag;
	end

	// left neighbour: the prime read, then each cell's lower neighbour for the next cell
	always_ff @(posedge clk) begin
		if (op_s1 != PH_IDLE) begin
			b_q <= tab_a_rd;
		end
	end

	// recurrence
	assign inner = gap_ge2_s1 ? tab_b_rd : '0;
	assign best  = (tab_a_rd > b_q) ? tab_a_rd : b_q;

	always_comb begin
		if (gap0_s1) begin
			cell_val = VW'(1);
		end else if (sym_a_rd == sym_b_rd) begin
			cell_val = inner + VW'(2);
		end else begin
			cell_val = best;
		end
	end

	// write back and report
	assign tab_wr_en   = (op_s1 == PH_CELL);
	assign tab_wr_addr = {i_s1, j_s1};
	assign tab_wr_data = cell_val;
	assign result      = cell_val;
	assign status.done = (op_s1 == PH_CELL) && final_s1;
	assign status.busy = (phase_q != PH_IDLE) || (op_s1 != PH_IDLE);

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !status.busy)
		else $error("fill started while busy");
	a_cell_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CELL) |-> (j <= nm1_q))
		else $error("cell beyond string end");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |=> !status.done)
		else $error("done repeated");
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> (result != '0) && (result <= VW'(nm1_q) + VW'(1)))
		else $error("score out of range");
`endif

endmodule

`default_nettype wire

// ===== src/longest_palindromic_subsequence_core.sv =====
// longest_palindromic_subsequence_core: top level, symbol load, fill control, result register
// depends on lps_pkg, lps_if, lps_ram and lps_fill
`default_nettype none

// Symbols are taken one per cycle until a beat with last_symbol set. Up to MAX_LEN symbols are
// kept; further ones are dropped and the result is flagged overflowed. After the last beat the
// interval table is filled one cell per cycle through a single table write port, diagonal by
// diagonal with a prime slot before each diagonal after the first. The result beat goes valid
// once the fill has scored the last cell, later only if the previous result beat is still waiting.
// No symbol is taken during scoring; the next string may load while the result beat still waits.

module longest_palindromic_subsequence_core #(
	parameter int MAX_LEN = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	lps_in_if.sink    symbols,
	lps_out_if.source result
);

	import lps_pkg::*;

	localparam int AW        = $clog2(MAX_LEN);
	localparam int CW        = $clog2(MAX_LEN + 1);
	localparam int TAB_DEPTH = 1 << (2 * AW);

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          out_valid_q;
	logic [LEN_W-1:0] out_len_q;
	logic          out_ovf_q;
	logic [CW-1:0] res_len_q;
	logic          res_ovf_q;

	logic          accept;
	logic          room;
	logic [CW-1:0] cnt_m1;
	logic          start;
	logic [AW-1:0] nm1;
	logic          out_free;

	logic [AW-1:0]    sym_a_addr;
	logic [AW-1:0]    sym_b_addr;
	logic [SYM_W-1:0] sym_a_rd;
	logic [SYM_W-1:0] sym_b_rd;
	logic [2*AW-1:0]  tab_a_addr;
	logic [2*AW-1:0]  tab_b_addr;
	logic [CW-1:0]    tab_a_rd;
	logic [CW-1:0]    tab_b_rd;
	logic             tab_wr_en;
	logic [2*AW-1:0]  tab_wr_addr;
	logic [CW-1:0]    tab_wr_data;
	fill_status_t     fill_status;
	logic [CW-1:0]    fill_result;

	// input beat handling
	assign symbols.ready = (state_q == ST_LOAD);
	assign accept        = symbols.valid && symbols.ready;
	assign room          = (cnt_q < CW'(MAX_LEN));
	assign cnt_m1        = cnt_q - CW'(1);
	assign start         = accept && symbols.last_symbol;
	assign nm1           = room ? cnt_q[AW-1:0] : cnt_m1[AW-1:0];
	assign out_free      = !out_valid_q || result.ready;

	// symbol store
	lps_ram #(
		.DW    (SYM_W),
		.DEPTH (MAX_LEN)
	) u_sym_store (
		.clk       (clk),
		.wr_en     (accept && room),
		.wr_addr   (cnt_q[AW-1:0]),
		.wr_data   (symbols.symbol),
		.rd_a_addr (sym_a_addr),
		.rd_b_addr (sym_b_addr),
		.rd_a_data (sym_a_rd),
		.rd_b_data (sym_b_rd)
	);

	// interval table, entry {i, j}
	lps_ram #(
		.DW    (CW),
		.DEPTH (TAB_DEPTH)
	) u_table (
		.clk       (clk),
		.wr_en     (tab_wr_en),
		.wr_addr   (tab_wr_addr),
		.wr_data   (tab_wr_data),
		.rd_a_addr (tab_a_addr),
		.rd_b_addr (tab_b_addr),
		.rd_a_data (tab_a_rd),
		.rd_b_data (tab_b_rd)
	);

	// table fill sequencer
	lps_fill #(
		.MAX_LEN (MAX_LEN)
	) u_fill (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.nm1         (nm1),
		.sym_a_addr  (sym_a_addr),
		.sym_b_addr  (sym_b_addr),
		.sym_a_rd    (sym_a_rd),
		.sym_b_rd    (sym_b_rd),
		.tab_a_addr  (tab_a_addr),
		.tab_b_addr  (tab_b_addr),
		.tab_a_rd    (tab_a_rd),
		.tab_b_rd    (tab_b_rd),
		.tab_wr_en   (tab_wr_en),
		.tab_wr_addr (tab_wr_addr),
		.tab_wr_data (tab_wr_data),
		.status      (fill_status),
		.result      (fill_result)
	);

	// load / score / deliver control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a beat taken in the deliver state is replaced there by the new one
			if (out_valid_q && result.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (symbols.last_symbol) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_FILL;
						end else if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_FILL: begin
					if (fill_status.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (start) begin
			res_ovf_q <= ovf_q || !room;
		end
		if (fill_status.done) begin
			res_len_q <= fill_result;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_len_q <= LEN_W'(res_len_q);
			out_ovf_q <= res_ovf_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.lps_length = out_len_q;
	assign result.overflowed = out_ovf_q;

endmodule

`default_nettype wire
